@@ rtl/digitizer_event_deframer_core_macros.svh @@
// Assertion macros of the deframer RTL, used by the controller.
// Self-contained; the asserting module includes this file by name.
`ifndef DIGITIZER_EVENT_DEFRAMER_CORE_MACROS_SVH
`define DIGITIZER_EVENT_DEFRAMER_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while reset is low.
`define DED_ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define DED_ASSERT(name, prop, msg) \
  `DED_ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/ded_pkg.sv @@
// Types and constants of the digitizer event deframer.
// No dependencies; imported by every deframer module.
`timescale 1ns / 1ps

package ded_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 28;
  localparam int unsigned ACTIVE_W = 5;
  localparam int unsigned PULSE_W  = 20;
  localparam int unsigned SIDX_W   = 21;
  localparam int unsigned SAMP_W   = 15;
  localparam int unsigned OFF_W    = 14;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned PIDX_W   = 8;
  localparam int unsigned PSTART_W = 22;
  localparam int unsigned EVNUM_W  = 24;
  localparam int unsigned TRIG_W   = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [OFF_W-1:0]  BASELINE_RST = 14'd4095;
  localparam logic [PIDX_W-1:0] PIDX_MAX     = 8'hFF;
  localparam logic              KIND_HEADER  = 1'b0;
  localparam logic              KIND_PAIR    = 1'b1;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_MASK,
    PH_NUMBER,
    PH_TIME,
    PH_DATA
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_SUPP = 2'd0,
    CFG_WIDE_MASK = 2'd1,
    CFG_BASELINE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load_out;
    logic div_start;
  } ded_cmd_t;

  typedef struct packed {
    logic produce;
    logic need_div;
    logic div_done;
  } ded_sts_t;

endpackage

@@ rtl/ded_if.sv @@
// Handshake channel interfaces of the deframer: readout words, results, register writes.
// Depends on ded_pkg for field widths.
`timescale 1ns / 1ps

interface ded_in_if;
  import ded_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface ded_out_if;
  import ded_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CH_W-1:0]            channel;
  logic [PIDX_W-1:0]          pulse_index;
  logic [SIDX_W-1:0]          sample_index;
  logic signed [SAMP_W-1:0]   sample_first;
  logic signed [SAMP_W-1:0]   sample_second;
  logic [PSTART_W-1:0]        pulse_start;
  logic [EVNUM_W-1:0]         event_number;
  logic [TRIG_W-1:0]          trigger_time;
  logic [MASK_W-1:0]          present_mask;
  logic                       last;
  modport source (output valid, output kind, output channel, output pulse_index,
                  output sample_index, output sample_first, output sample_second,
                  output pulse_start, output event_number, output trigger_time,
                  output present_mask, output last, input ready);
  modport sink   (input valid, input kind, input channel, input pulse_index,
                  input sample_index, input sample_first, input sample_second,
                  input pulse_start, input event_number, input trigger_time,
                  input present_mask, input last, output ready);
endinterface

interface ded_cfg_if;
  import ded_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ded_div.sv @@
// Restoring divider, one quotient bit per cycle, for words per channel.
// Depends on ded_pkg.
`timescale 1ns / 1ps

module ded_div import ded_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [COUNT_W-1:0]  dividend_i,
  input  logic [ACTIVE_W-1:0] divisor_i,
  output logic                done_o,
  output logic [COUNT_W-1:0]  quotient_o
);

  localparam int unsigned ITER_W = $clog2(COUNT_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(COUNT_W - 1);

  logic                  busy_q, busy_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [COUNT_W-1:0]    quo_q, quo_d;
  logic [ACTIVE_W-2:0]   rem_q, rem_d;
  logic [ACTIVE_W-1:0]   div_q, div_d;
  logic [ACTIVE_W-1:0]   rem_sh;
  logic                  qbit;

  // The remainder stays below the divisor (at most 16), so four bits hold it.
  assign rem_sh     = {rem_q, quo_q[COUNT_W-1]};
  assign qbit       = (rem_sh >= div_q);
  assign done_o     = busy_q && (iter_q == ITER_LAST);
  assign quotient_o = {quo_q[COUNT_W-2:0], qbit};

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[COUNT_W-2:0], qbit};
      rem_d  = qbit ? (ACTIVE_W-1)'(rem_sh - div_q) : rem_sh[ACTIVE_W-2:0];
      iter_d = iter_q + 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

@@ rtl/ded_ctrl.sv @@
// Controller of the deframer: input and output handshakes, divide wait state.
// Depends on ded_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "digitizer_event_deframer_core_macros.svh"

module ded_ctrl import ded_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  ded_sts_t sts_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output ded_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && in_ready_o && sts_i.need_div) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // In the run state, a new word is taken whenever the result register is free or being emptied.
  always_comb begin
    in_ready_o        = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
    cmd_o.accept      = in_valid_i && in_ready_o;
    cmd_o.load_out    = cmd_o.accept && sts_i.produce;
    cmd_o.div_start   = cmd_o.accept && sts_i.need_div;
    out_valid_d       = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DED_ASSERT(a_div_enter, cmd_o.div_start |=> state_q == ST_DIV, "divide start did not enter wait state")
  `DED_ASSERT(a_div_done_in_wait, sts_i.div_done |-> state_q == ST_DIV, "divide finished outside wait state")
  `DED_ASSERT(a_no_overwrite, cmd_o.load_out |-> !(out_valid_q && !out_ready_i), "pending result overwritten")

endmodule

@@ rtl/ded_dp.sv @@
// Datapath of the deframer: header and event state, word decode, result register.
// Depends on ded_pkg and ded_div.
`timescale 1ns / 1ps

module ded_dp import ded_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ded_cmd_t                cmd_i,
  output ded_sts_t                sts_o,
  input  logic [WORD_W-1:0]       data_word_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    kind_o,
  output logic [CH_W-1:0]         channel_o,
  output logic [PIDX_W-1:0]       pulse_index_o,
  output logic [SIDX_W-1:0]       sample_index_o,
  output logic signed [SAMP_W-1:0] sample_first_o,
  output logic signed [SAMP_W-1:0] sample_second_o,
  output logic [PSTART_W-1:0]     pulse_start_o,
  output logic [EVNUM_W-1:0]      event_number_o,
  output logic [TRIG_W-1:0]       trigger_time_o,
  output logic [MASK_W-1:0]       present_mask_o,
  output logic                    last_o
);

  localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((64'd1 << NUM_CHANNELS) - 64'd1);

  // Configuration registers.
  logic              zs_q;
  logic              wide_q;
  logic [OFF_W-1:0]  off_q;

  // Event state.
  phase_e             phase_q, phase_d;
  logic [COUNT_W-1:0] wl_q, wl_d;
  logic [MASK_W-1:0]  mleft_q, mleft_d;
  logic [MASK_W-1:0]  emask_q, emask_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [COUNT_W-1:0] wpc_q, wpc_d;
  logic [COUNT_W-1:0] cwl_q, cwl_d;
  logic [PULSE_W-1:0] pwl_q, pwl_d;
  logic [PULSE_W-1:0] tc_q, tc_d;
  logic [PIDX_W-1:0]  pc_q, pc_d;
  logic [SIDX_W-1:0]  sc_q, sc_d;
  logic [EVNUM_W-1:0] evnum_q, evnum_d;
  logic [TRIG_W-1:0]  trig_q, trig_d;

  // Result register.
  logic                    o_kind_q;
  logic [CH_W-1:0]         o_ch_q;
  logic [PIDX_W-1:0]       o_pidx_q;
  logic [SIDX_W-1:0]       o_sidx_q;
  logic [SAMP_W-1:0]       o_s1_q, o_s2_q;
  logic [PSTART_W-1:0]     o_pstart_q;
  logic [EVNUM_W-1:0]      o_evnum_q;
  logic [TRIG_W-1:0]       o_trig_q;
  logic [MASK_W-1:0]       o_mask_q;
  logic                    o_last_q;

  // Decode of the current word.
  logic                    r_kind;
  logic [CH_W-1:0]         r_ch;
  logic [PIDX_W-1:0]       r_pidx;
  logic [SIDX_W-1:0]       r_sidx;
  logic [PSTART_W-1:0]     r_pstart;
  logic [TRIG_W-1:0]       r_trig;
  logic                    r_last;
  logic                    produce;

  logic [WORD_W-1:0]   w;
  logic                first_found;
  logic [CH_W-1:0]     first_idx;
  logic [MASK_W-1:0]   hdr_mask;
  logic [ACTIVE_W-1:0] act_cnt;
  logic [COUNT_W-1:0]  wl_hdr;
  logic [COUNT_W-1:0]  wl_dec;
  logic [COUNT_W-1:0]  size_field;
  logic [PULSE_W-1:0]  len_field;
  logic [PULSE_W-1:0]  start_pos;
  logic [SAMP_W-1:0]   off_ext;
  logic [SAMP_W-1:0]   samp_a, samp_b;
  logic                div_done;
  logic [COUNT_W-1:0]  div_quot;

  assign w          = data_word_i;
  assign hdr_mask   = emask_q & CH_MASK;
  assign wl_hdr     = (wl_q > COUNT_W'(4)) ? wl_q - COUNT_W'(4) : '0;
  assign wl_dec     = (wl_q != '0) ? wl_q - 1'b1 : '0;
  assign size_field = w[COUNT_W-1:0];
  assign len_field  = w[PULSE_W-1:0];
  assign start_pos  = tc_q - sc_q[SIDX_W-1:1];
  assign off_ext    = zs_q ? {1'b0, off_q} : '0;
  assign samp_a     = {1'b0, w[13:0]} - off_ext;
  assign samp_b     = {1'b0, w[29:16]} - off_ext;

  // Lowest remaining channel and active channel count.
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    act_cnt     = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mleft_q[i]) begin
        first_found = 1'b1;
        first_idx   = CH_W'(i);
      end
    end
    for (int i = 0; i < MASK_W; i++) begin
      act_cnt = act_cnt + ACTIVE_W'(hdr_mask[i]);
    end
  end

  ded_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (wl_hdr),
    .divisor_i  (act_cnt),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign sts_o.produce  = produce;
  assign sts_o.need_div = (phase_q == PH_TIME) && (act_cnt != '0);
  assign sts_o.div_done = div_done;

  always_comb begin
    phase_d  = phase_q;
    wl_d     = wl_q;
    mleft_d  = mleft_q;
    emask_d  = emask_q;
    ch_d     = ch_q;
    wpc_d    = wpc_q;
    cwl_d    = cwl_q;
    pwl_d    = pwl_q;
    tc_d     = tc_q;
    pc_d     = pc_q;
    sc_d     = sc_q;
    evnum_d  = evnum_q;
    trig_d   = trig_q;
    produce  = 1'b0;
    r_kind   = KIND_PAIR;
    r_ch     = '0;
    r_pidx   = '0;
    r_sidx   = '0;
    r_pstart = '0;
    r_trig   = trig_q;
    r_last   = (wl_dec == '0);

    unique case (phase_q)
      PH_SIZE: begin
        wl_d    = size_field;
        phase_d = PH_MASK;
      end
      PH_MASK: begin
        emask_d = {8'h00, w[7:0]};
        phase_d = PH_NUMBER;
      end
      PH_NUMBER: begin
        evnum_d = w[EVNUM_W-1:0];
        trig_d  = '0;
        if (wide_q) begin
          emask_d[15:8] = w[31:24];
        end
        phase_d = PH_TIME;
      end
      PH_TIME: begin
        trig_d  = w[TRIG_W-1:0];
        wl_d    = wl_hdr;
        mleft_d = hdr_mask;
        // With channels active the divider fills in words per channel.
        wpc_d   = '0;
        ch_d    = '0;
        cwl_d   = '0;
        pwl_d   = '0;
        tc_d    = '0;
        pc_d    = '0;
        sc_d    = '0;
        produce = 1'b1;
        r_kind  = KIND_HEADER;
        r_trig  = w[TRIG_W-1:0];
        r_last  = (wl_hdr == '0);
        phase_d = r_last ? PH_SIZE : PH_DATA;
      end
      PH_DATA: begin
        wl_d    = wl_dec;
        phase_d = r_last ? PH_SIZE : PH_DATA;
        if (!zs_q) begin
          if (cwl_q == '0) begin
            if ((wpc_q != '0) && first_found) begin
              mleft_d = mleft_q & ~(MASK_W'(1) << first_idx);
              ch_d    = first_idx;
              r_ch    = first_idx;
              r_sidx  = '0;
              cwl_d   = wpc_q - 1'b1;
              sc_d    = SIDX_W'(2);
              produce = 1'b1;
            end
          end else begin
            r_ch    = ch_q;
            r_sidx  = sc_q;
            cwl_d   = cwl_q - 1'b1;
            sc_d    = sc_q + SIDX_W'(2);
            produce = 1'b1;
          end
        end else if ((cwl_q == '0) && (pwl_q == '0)) begin
          // Channel size word: opens the next channel block.
          cwl_d = (size_field != '0) ? size_field - 1'b1 : '0;
          if (first_found) begin
            mleft_d = mleft_q & ~(MASK_W'(1) << first_idx);
            ch_d    = first_idx;
          end
          tc_d = '0;
          pc_d = '0;
          sc_d = '0;
        end else begin
          if (cwl_q != '0) begin
            cwl_d = cwl_q - 1'b1;
          end
          if (pwl_q == '0) begin
            // Control word: bit 31 clear skips time, set opens a pulse.
            if (!w[31]) begin
              tc_d = tc_q + len_field;
            end else begin
              sc_d  = '0;
              pwl_d = len_field;
              if ((len_field == '0) && (pc_q != PIDX_MAX)) begin
                pc_d = pc_q + 1'b1;
              end
            end
          end else begin
            r_ch     = ch_q;
            r_pidx   = pc_q;
            r_sidx   = sc_q;
            r_pstart = {start_pos, 2'b00};
            produce  = 1'b1;
            sc_d     = sc_q + SIDX_W'(2);
            tc_d     = tc_q + 1'b1;
            pwl_d    = pwl_q - 1'b1;
            if ((pwl_q == PULSE_W'(1)) && (pc_q != PIDX_MAX)) begin
              pc_d = pc_q + 1'b1;
            end
          end
        end
      end
      default: phase_d = PH_SIZE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zs_q    <= 1'b0;
      wide_q  <= 1'b0;
      off_q   <= BASELINE_RST;
      phase_q <= PH_SIZE;
      wl_q    <= '0;
      mleft_q <= '0;
      emask_q <= '0;
      ch_q    <= '0;
      wpc_q   <= '0;
      cwl_q   <= '0;
      pwl_q   <= '0;
      tc_q    <= '0;
      pc_q    <= '0;
      sc_q    <= '0;
      evnum_q <= '0;
      trig_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ZERO_SUPP: zs_q   <= cfg_data_i[0];
          CFG_WIDE_MASK: wide_q <= cfg_data_i[0];
          CFG_BASELINE:  off_q  <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        phase_q <= phase_d;
        wl_q    <= wl_d;
        mleft_q <= mleft_d;
        emask_q <= emask_d;
        ch_q    <= ch_d;
        wpc_q   <= wpc_d;
        cwl_q   <= cwl_d;
        pwl_q   <= pwl_d;
        tc_q    <= tc_d;
        pc_q    <= pc_d;
        sc_q    <= sc_d;
        evnum_q <= evnum_d;
        trig_q  <= trig_d;
      end else if (div_done) begin
        wpc_q <= div_quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_kind_q   <= r_kind;
      o_ch_q     <= r_ch;
      o_pidx_q   <= r_pidx;
      o_sidx_q   <= r_sidx;
      o_s1_q     <= (r_kind == KIND_PAIR) ? samp_a : '0;
      o_s2_q     <= (r_kind == KIND_PAIR) ? samp_b : '0;
      o_pstart_q <= r_pstart;
      o_evnum_q  <= evnum_q;
      o_trig_q   <= r_trig;
      o_mask_q   <= emask_q;
      o_last_q   <= r_last;
    end
  end

  assign kind_o          = o_kind_q;
  assign channel_o       = o_ch_q;
  assign pulse_index_o   = o_pidx_q;
  assign sample_index_o  = o_sidx_q;
  assign sample_first_o  = o_s1_q;
  assign sample_second_o = o_s2_q;
  assign pulse_start_o   = o_pstart_q;
  assign event_number_o  = o_evnum_q;
  assign trigger_time_o  = o_trig_q;
  assign present_mask_o  = o_mask_q;
  assign last_o          = o_last_q;

endmodule

@@ rtl/digitizer_event_deframer_core.sv @@
// Output: a result is loaded into the output register as its word is accepted.
// Input: one readout word per cycle while the result register is free or being emptied,
// except after the trigger-time header word of an event with active channels, where the
// bit-serial divide for words per channel (one quotient bit per cycle) holds off the next word.
// Reset: asynchronous, active low; clears all event state, baseline offset returns to 4095.
// Depends on ded_pkg, ded_if, ded_ctrl, ded_dp.
`timescale 1ns / 1ps

module digitizer_event_deframer_core import ded_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ded_in_if.sink       in_if,
  ded_out_if.source    out_if,
  ded_cfg_if.sink      cfg_if
);

  ded_cmd_t cmd;
  ded_sts_t sts;

  // Register writes are taken in any cycle.
  assign cfg_if.ready = 1'b1;

  ded_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  ded_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_word_i     (in_if.data_word),
    .cfg_we_i        (cfg_if.valid),
    .cfg_index_i     (cfg_if.index),
    .cfg_data_i      (cfg_if.data),
    .kind_o          (out_if.kind),
    .channel_o       (out_if.channel),
    .pulse_index_o   (out_if.pulse_index),
    .sample_index_o  (out_if.sample_index),
    .sample_first_o  (out_if.sample_first),
    .sample_second_o (out_if.sample_second),
    .pulse_start_o   (out_if.pulse_start),
    .event_number_o  (out_if.event_number),
    .trigger_time_o  (out_if.trigger_time),
    .present_mask_o  (out_if.present_mask),
    .last_o          (out_if.last)
  );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the digitizer event deframer: directed and random readout streams.
// Depends on ded_pkg, the ded_if channel interfaces and digitizer_event_deframer_core.
`timescale 1ns / 1ps

import ded_pkg::*;

typedef struct packed {
  logic                kind;
  logic [CH_W-1:0]     channel;
  logic [PIDX_W-1:0]   pulse_index;
  logic [SIDX_W-1:0]   sample_index;
  logic [SAMP_W-1:0]   sample_first;
  logic [SAMP_W-1:0]   sample_second;
  logic [PSTART_W-1:0] pulse_start;
  logic [EVNUM_W-1:0]  event_number;
  logic [TRIG_W-1:0]   trigger_time;
  logic [MASK_W-1:0]   present_mask;
  logic                last;
} deframe_result_t;

class deframe_scoreboard #(int unsigned CHANNELS = 8);
  bit               zero_supp;
  bit               wide_mask;
  logic [OFF_W-1:0] baseline;

  phase_e              phase;
  logic [COUNT_W-1:0]  words_left;
  logic [COUNT_W-1:0]  words_per_ch;
  logic [COUNT_W-1:0]  ch_words_left;
  logic [MASK_W-1:0]   mask_left;
  logic [MASK_W-1:0]   event_mask;
  logic [CH_W-1:0]     cur_ch;
  logic [PULSE_W-1:0]  pulse_words_left;
  logic [PULSE_W-1:0]  time_count;
  logic [PIDX_W-1:0]   pulse_count;
  logic [SIDX_W-1:0]   sample_count;
  logic [EVNUM_W-1:0]  event_number;
  logic [TRIG_W-1:0]   trigger_time;

  deframe_result_t expected_q[$];
  int errors;

  function new();
    zero_supp = 1'b0;
    wide_mask = 1'b0;
    baseline = BASELINE_RST;
    phase = PH_SIZE;
    words_left = '0;
    words_per_ch = '0;
    ch_words_left = '0;
    mask_left = '0;
    event_mask = '0;
    cur_ch = '0;
    pulse_words_left = '0;
    time_count = '0;
    pulse_count = '0;
    sample_count = '0;
    event_number = '0;
    trigger_time = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_config(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ZERO_SUPP: zero_supp = value[0];
      CFG_WIDE_MASK: wide_mask = value[0];
      CFG_BASELINE:  baseline = value[OFF_W-1:0];
      default: ;
    endcase
  endfunction

  // Moves to the lowest channel still pending in this event.
  function bit take_next_channel();
    for (int i = 0; i < 16; i++) begin
      if (mask_left[i]) begin
        mask_left[i] = 1'b0;
        cur_ch = CH_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function void push_result(bit is_pair, logic [WORD_W-1:0] w, logic [OFF_W-1:0] off,
                            logic [PIDX_W-1:0] pidx, logic [PULSE_W-1:0] start, bit last_word);
    deframe_result_t r;
    r = '0;
    r.kind = is_pair ? KIND_PAIR : KIND_HEADER;
    if (is_pair) begin
      r.channel = cur_ch;
      r.pulse_index = pidx;
      r.sample_index = sample_count;
      r.sample_first = {1'b0, w[13:0]} - {1'b0, off};
      r.sample_second = {1'b0, w[29:16]} - {1'b0, off};
      r.pulse_start = {start, 2'b00};
    end
    r.event_number = event_number;
    r.trigger_time = trigger_time;
    r.present_mask = event_mask;
    r.last = last_word;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void note_word(logic [WORD_W-1:0] w);
    int unsigned active;
    logic [PULSE_W-1:0] start;
    logic [COUNT_W-1:0] sz;
    bit last_word;
    case (phase)
      PH_SIZE: begin
        words_left = w[27:0];
        phase = PH_MASK;
        return;
      end
      PH_MASK: begin
        event_mask = {8'h00, w[7:0]};
        phase = PH_NUMBER;
        return;
      end
      PH_NUMBER: begin
        event_number = w[23:0];
        if (wide_mask) event_mask[15:8] = event_mask[15:8] | w[31:24];
        phase = PH_TIME;
        return;
      end
      PH_TIME: begin
        trigger_time = w[30:0];
        words_left = (words_left > COUNT_W'(4)) ? words_left - COUNT_W'(4) : '0;
        mask_left = event_mask & 16'((32'd1 << CHANNELS) - 1);
        active = $countones(mask_left);
        words_per_ch = (active != 0) ? COUNT_W'(words_left / active) : '0;
        cur_ch = '0;
        ch_words_left = '0;
        pulse_words_left = '0;
        time_count = '0;
        pulse_count = '0;
        sample_count = '0;
        last_word = (words_left == 0);
        phase = last_word ? PH_SIZE : PH_DATA;
        push_result(1'b0, w, '0, '0, '0, last_word);
        return;
      end
      default: ;
    endcase

    if (words_left != 0) words_left--;
    last_word = (words_left == 0);
    if (last_word) phase = PH_SIZE;

    if (!zero_supp) begin
      // Full layout: leftover words, and all words with no active channel, are dropped.
      if (ch_words_left == 0) begin
        if (words_per_ch == 0) return;
        if (!take_next_channel()) return;
        ch_words_left = words_per_ch;
        sample_count = '0;
      end
      push_result(1'b1, w, '0, '0, '0, last_word);
      ch_words_left--;
      sample_count += SIDX_W'(2);
      return;
    end

    if (ch_words_left == 0 && pulse_words_left == 0) begin
      sz = w[27:0];
      ch_words_left = (sz != 0) ? sz - 1'b1 : '0;
      void'(take_next_channel());
      time_count = '0;
      pulse_count = '0;
      sample_count = '0;
      return;
    end
    if (ch_words_left != 0) ch_words_left--;

    if (pulse_words_left == 0) begin
      if (!w[31]) begin
        time_count += w[19:0];
      end else begin
        sample_count = '0;
        pulse_words_left = w[19:0];
        if (w[19:0] == 0 && pulse_count != PIDX_MAX) pulse_count++;
      end
      return;
    end

    start = time_count - sample_count[20:1];
    push_result(1'b1, w, baseline, pulse_count, start, last_word);
    sample_count += SIDX_W'(2);
    time_count += PULSE_W'(1);
    pulse_words_left--;
    if (pulse_words_left == 0 && pulse_count != PIDX_MAX) pulse_count++;
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(deframe_result_t got);
    deframe_result_t want;
    if (expected_q.size() == 0) begin
      $error("result transfer with no expected result pending");
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("channel", want.channel, got.channel);
    compare_field("pulse_index", want.pulse_index, got.pulse_index);
    compare_field("sample_index", want.sample_index, got.sample_index);
    compare_field("sample_first", want.sample_first, got.sample_first);
    compare_field("sample_second", want.sample_second, got.sample_second);
    compare_field("pulse_start", want.pulse_start, got.pulse_start);
    compare_field("event_number", want.event_number, got.event_number);
    compare_field("trigger_time", want.trigger_time, got.trigger_time);
    compare_field("present_mask", want.present_mask, got.present_mask);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb_top;

  localparam int unsigned NUM_CH         = 8;
  localparam int unsigned TARGET_WORDS   = 1650;
  localparam int unsigned PHASE_WORDS    = 150;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  ded_in_if  in_if ();
  ded_out_if out_if ();
  ded_cfg_if cfg_if ();

  digitizer_event_deframer_core #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  deframe_scoreboard #(NUM_CH) sb;

  logic [WORD_W-1:0] event_words[$];
  int unsigned       words_sent = 0;
  int unsigned       in_max_gap = 12;
  int unsigned       out_max_stall = 12;
  bit                hold_request = 1'b0;
  int unsigned       stuck_cycles = 0;
  bit                cur_zs;
  bit                cur_wide;
  logic [OFF_W-1:0]  cur_base;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(logic [WORD_W-1:0] w);
    int unsigned gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_word <= w;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  // Waits until every expected result is out and the divider has had time to finish.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_config(idx, value);
  endtask

  task automatic write_config(bit zs, bit wide, logic [OFF_W-1:0] base);
    cfg_transfer(CFG_ZERO_SUPP, CFG_DATA_W'(zs));
    cfg_transfer(CFG_WIDE_MASK, CFG_DATA_W'(wide));
    cfg_transfer(CFG_BASELINE, base);
    cfg_if.valid <= 1'b0;
  endtask

  // One zero-suppressed channel block: size word, then skips and pulses.
  task automatic gen_zs_block(bit pulse_burst);
    logic [WORD_W-1:0] body[$];
    int unsigned len;
    int unsigned count;
    if (pulse_burst) begin
      // Enough empty pulses to saturate the pulse index, then a real one.
      repeat (260) body.insert(body.size(), 32'h8000_0000);
      body.insert(body.size(), 32'h8000_0002);
      body.insert(body.size(), $urandom);
      body.insert(body.size(), $urandom);
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) body.insert(body.size(), $urandom & 32'h7FFF_FFFF);
        else body.insert(body.size(), ($urandom & 32'h7FF0_0000) | $urandom_range(0, 40));
      end else begin
        len = $urandom_range(0, 4);
        body.insert(body.size(), 32'h8000_0000 | ($urandom & 32'h7FF0_0000) | len);
        repeat (len) body.insert(body.size(), $urandom);
      end
    end
    count = body.size() + 1;
    if ($urandom_range(0, 9) == 0) count = $urandom_range(0, count + 2);
    event_words.insert(event_words.size(), ($urandom & 32'hF000_0000) | count);
    foreach (body[i]) event_words.insert(event_words.size(), body[i]);
  endtask

  task automatic gen_event(bit zs_layout, bit pulse_burst);
    logic [7:0]  mask_lo;
    int unsigned active;
    int unsigned nblocks;
    int unsigned ndata;
    int unsigned size_field;
    event_words.delete();
    case ($urandom_range(0, 9))
      0: mask_lo = 8'h00;
      1: mask_lo = 8'hFF;
      default: mask_lo = 8'($urandom);
    endcase
    active = $countones(mask_lo & 8'((32'd1 << NUM_CH) - 1));
    if ($urandom_range(0, 15) == 0 && !pulse_burst) begin
      size_field = $urandom_range(0, 4);
    end else begin
      if (!zs_layout) begin
        ndata = $urandom_range(0, 6) * active;
        ndata += (active != 0) ? $urandom_range(0, active - 1) : $urandom_range(0, 3);
        repeat (ndata) event_words.insert(event_words.size(), $urandom);
      end else begin
        nblocks = active + (($urandom_range(0, 7) == 0) ? 1 : 0);
        if (pulse_burst && nblocks == 0) nblocks = 1;
        for (int b = 0; b < nblocks; b++) gen_zs_block(pulse_burst && b == 0);
      end
      size_field = 4 + event_words.size();
    end
    event_words.push_front($urandom);
    event_words.push_front($urandom);
    event_words.push_front({24'($urandom), mask_lo});
    event_words.push_front(($urandom & 32'hF000_0000) | size_field);
  endtask

  task automatic send_event(bit allow_split);
    int unsigned split_at;
    split_at = event_words.size();
    if (allow_split && $urandom_range(0, 11) == 0)
      split_at = $urandom_range(1, event_words.size() - 1);
    foreach (event_words[i]) begin
      if (i == split_at) begin
        // Switch the layout in the middle of the event.
        wait_idle();
        cur_zs = !cur_zs;
        write_config(cur_zs, cur_wide, cur_base);
      end
      send_word(event_words[i]);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, and the check.
  initial begin
    deframe_result_t got;
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      stall = $urandom_range(0, out_max_stall);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (out_if.valid !== 1'b1) @(posedge clk_i);
      got.kind = out_if.kind;
      got.channel = out_if.channel;
      got.pulse_index = out_if.pulse_index;
      got.sample_index = out_if.sample_index;
      got.sample_first = out_if.sample_first;
      got.sample_second = out_if.sample_second;
      got.pulse_start = out_if.pulse_start;
      got.event_number = out_if.event_number;
      got.trigger_time = out_if.trigger_time;
      got.present_mask = out_if.present_mask;
      got.last = out_if.last;
      sb.check_result(got);
    end
  end

  initial begin
    int  phase_no;
    int  unsigned phase_end;
    bit  burst;
    sb = new();
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_word <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_ZERO_SUPP;
    cfg_if.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full layout at reset settings: a header-only short event, an event with a
    // leftover word that swallows the last flag, and an event with no active channel.
    event_words = '{32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h0000_0009, 32'h0000_0003, 32'h0000_0000, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h0000_0000, 32'h3FFF_3FFF, 32'hC000_C000,
                    32'h1234_5678,
                    32'h0000_0005, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                    32'hA5A5_5A5A};
    send_event(1'b0);
    wait_idle();

    // Zero-suppressed with the wide mask and the largest offset: mask bits beyond the
    // channel count, a time wrap, an empty pulse, a channel advance past the last
    // active channel, and a pulse longer than its channel.
    cur_zs = 1'b1;
    cur_wide = 1'b1;
    cur_base = 14'h3FFF;
    write_config(cur_zs, cur_wide, cur_base);
    event_words = '{32'h0000_000F, 32'hFFFF_FF01, 32'hFFAB_CDEF, 32'h8000_0000,
                    32'hF000_0007, 32'h7FFF_FFFF, 32'h0000_0005, 32'h8000_0000,
                    32'h8000_0002, 32'h3FFF_0000, 32'hC000_3FFF,
                    32'h0000_0002, 32'h8000_0002, 32'hFFFF_FFFF, 32'h0000_0000};
    send_event(1'b0);

    phase_no = 0;
    while (words_sent < TARGET_WORDS) begin
      wait_idle();
      cur_zs = phase_no[0];
      cur_wide = phase_no[1];
      case (phase_no)
        0: cur_base = '0;
        1: cur_base = 14'h3FFF;
        default: cur_base = OFF_W'($urandom_range(0, 16383));
      endcase
      write_config(cur_zs, cur_wide, cur_base);
      case (phase_no % 4)
        0: begin in_max_gap = 12; out_max_stall = 12; end
        1: begin in_max_gap = 0;  out_max_stall = 0;  end
        2: begin in_max_gap = 0;  out_max_stall = 12; end
        default: begin in_max_gap = 12; out_max_stall = 0; end
      endcase
      if (phase_no == 2) hold_request = 1'b1;
      burst = (phase_no == 1);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        gen_event(cur_zs, burst);
        send_event(!burst);
        burst = 1'b0;
      end
      phase_no++;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ digitizer_event_deframer_core.f @@
+incdir+rtl
rtl/ded_pkg.sv
rtl/ded_if.sv
rtl/ded_div.sv
rtl/ded_ctrl.sv
rtl/ded_dp.sv
rtl/digitizer_event_deframer_core.sv
bench/tb_top.sv
